FILE: rtl/pis_pkg.sv
// shared types and constants for the priority insertion sorter
`default_nettype none

package pis_pkg;

    // field widths
    localparam int HANDLE_W = 16;
    localparam int KEY_W    = 16;

    // default store depth
    localparam int MAX_ENTRIES_DEF = 64;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_EMIT_RD,
        ST_EMIT_LD
    } pis_state_t;

endpackage : pis_pkg

`default_nettype wire

FILE: rtl/priority_insertion_sorter_top.sv
// Stable descending insertion sorter over a store of entries.
//
// Input words (entry_handle, priority_key, last_entry) arrive on a valid/ready
// channel; in_ready is high only while the sequencer is idle. Each word is
// inserted into a store held in descending key order; the stored entries with a
// smaller key are read, compared and shifted up one place at a time, starting
// from the back of the store, and the word is then written into the place left
// free. A word that arrives with the store full is dropped and flags overflow
// for that list.
// After the word marked last the whole store is emitted on the output
// valid/ready channel, each word as a store read then an output load,
// with run_end on the final word and overflow on every word of a list that
// lost entries. The count and the drop flag then return to zero.
// A registered output stage holds a word while the receiver stalls; emission
// waits for it to drain, and the next list may start loading as soon as the
// last word sits in the output stage. Reset clears the count, the drop flag,
// the sequencer and the output valid; the store itself is not cleared.
`default_nettype none

module priority_insertion_sorter_top
    import pis_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [HANDLE_W-1:0] entry_handle,
    input  wire logic [KEY_W-1:0]    priority_key,
    input  wire logic                last_entry,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [HANDLE_W-1:0]      sorted_handle,
    output logic [KEY_W-1:0]         sorted_priority,
    output logic                     run_end,
    output logic                     overflow
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WORD_W = KEY_W + HANDLE_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // sequencer and datapath registers
    pis_state_t           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [HANDLE_W-1:0]  new_handle_reg, new_handle_next;
    logic [KEY_W-1:0]     new_key_reg, new_key_next;
    logic                 last_reg, last_next;

    // output stage
    logic                 out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic [KEY_W-1:0]     out_key_reg, out_key_next;
    logic                 out_end_reg, out_end_next;
    logic                 out_ovf_reg, out_ovf_next;

    // entry store: key in the upper half, handle in the lower half
    logic [WORD_W-1:0]    store_mem [MAX_ENTRIES];
    logic [WORD_W-1:0]    rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [WORD_W-1:0]    wr_data;

    logic                 in_fire;
    logic                 rd_less;
    logic                 out_free;
    logic                 emit_last;
    logic [CNT_W-1:0]     pos_dec;
    logic [CNT_W-1:0]     idx_inc;

    assign in_fire   = in_valid && (state_reg == ST_IDLE);
    assign rd_less   = rd_data_reg[WORD_W-1:HANDLE_W] < new_key_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pos_dec   = pos_reg - CNT_ONE;
    assign idx_inc   = idx_reg + CNT_ONE;
    assign emit_last = (idx_inc == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (count_reg == CNT_FULL)
                        state_next = last_entry ? ST_EMIT_RD : ST_IDLE;
                    else if (count_reg == '0)
                        state_next = ST_INS_PUT;
                    else
                        state_next = ST_INS_RD;
                end
            end
            ST_INS_RD:
                state_next = ST_INS_CMP;
            ST_INS_CMP:
            begin
                if (rd_less && (pos_reg != CNT_ONE))
                    state_next = ST_INS_RD;
                else
                    state_next = ST_INS_PUT;
            end
            ST_INS_PUT:
                state_next = last_reg ? ST_EMIT_RD : ST_IDLE;
            ST_EMIT_RD:
                state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (out_free)
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath, store port and output stage controls
    always_comb
    begin
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        new_handle_next = new_handle_reg;
        new_key_next    = new_key_reg;
        last_next       = last_reg;
        out_handle_next = out_handle_reg;
        out_key_next    = out_key_reg;
        out_end_next    = out_end_reg;
        out_ovf_next    = out_ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        rd_addr         = pos_dec[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = pos_reg[IDX_W-1:0];
        wr_data         = {new_key_reg, new_handle_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    new_handle_next = entry_handle;
                    new_key_next    = priority_key;
                    last_next       = last_entry;
                    pos_next        = count_reg;
                    idx_next        = '0;
                    if (count_reg == CNT_FULL)
                        dropped_next = 1'b1;
                end
            end
            ST_INS_RD:
                rd_addr = pos_dec[IDX_W-1:0];
            ST_INS_CMP:
            begin
                // shift a smaller stored entry up by one place
                if (rd_less)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data_reg;
                    pos_next = pos_dec;
                end
            end
            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_ONE;
            end
            ST_EMIT_RD:
                rd_addr = idx_reg[IDX_W-1:0];
            ST_EMIT_LD:
            begin
                rd_addr = idx_reg[IDX_W-1:0];
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = rd_data_reg[HANDLE_W-1:0];
                    out_key_next    = rd_data_reg[WORD_W-1:HANDLE_W];
                    out_end_next    = emit_last;
                    out_ovf_next    = dropped_reg;
                    idx_next        = idx_inc;
                    if (emit_last)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        new_handle_reg <= new_handle_next;
        new_key_reg    <= new_key_next;
        last_reg       <= last_next;
        out_handle_reg <= out_handle_next;
        out_key_reg    <= out_key_next;
        out_end_reg    <= out_end_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        rd_data_reg <= store_mem[rd_addr];
    end

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign sorted_handle   = out_handle_reg;
    assign sorted_priority = out_key_reg;
    assign run_end         = out_end_reg;
    assign overflow        = out_ovf_reg;

endmodule : priority_insertion_sorter_top

`default_nettype wire
